// ===== rtl/cfd_pkg.sv =====
`timescale 1ns / 1ps

package cfd_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;

  localparam logic [7:0] CODE_FULL = 8'hFF;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // result queue; an item may push two entries
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

// ===== rtl/cfd_step.sv =====
`timescale 1ns / 1ps

module cfd_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  cfd_pkg::item_t item,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  output cfd_pkg::push_t push
);

  logic [15:0] out_capacity;
  logic [7:0]  block_remaining, block_remaining_next;
  logic        zero_pending, zero_pending_next;
  logic        first_block, first_block_next;
  logic [15:0] bytes_written, bytes_written_next;
  logic        dropping_frame, dropping_frame_next;

  logic        byte_emit;
  logic [7:0]  byte_val;
  logic        end_emit;
  logic [1:0]  end_status;
  logic [15:0] end_len;
  logic        closing;
  logic        err;

  always_comb begin
    block_remaining_next = block_remaining;
    zero_pending_next    = zero_pending;
    first_block_next     = first_block;
    bytes_written_next   = bytes_written;
    dropping_frame_next  = dropping_frame;
    byte_emit  = 1'b0;
    byte_val   = 8'd0;
    end_emit   = 1'b0;
    end_status = cfd_pkg::ST_OK;
    end_len    = 16'd0;
    err        = 1'b0;
    closing    = item.last_byte || !item.has_byte;

    if (dropping_frame) begin
      if (closing) begin
        dropping_frame_next = 1'b0;
      end
    end else begin
      if (item.has_byte) begin
        if (block_remaining != 8'd0) begin
          if (bytes_written >= out_capacity) begin
            err        = 1'b1;
            end_status = cfd_pkg::ST_TOO_SMALL;
          end else begin
            byte_emit            = 1'b1;
            byte_val             = item.in_byte;
            bytes_written_next   = bytes_written + 16'd1;
            block_remaining_next = block_remaining - 8'd1;
          end
        end else begin
          if (!first_block && zero_pending) begin
            if (bytes_written >= out_capacity) begin
              err        = 1'b1;
              end_status = cfd_pkg::ST_TOO_SMALL;
            end else begin
              byte_emit          = 1'b1;
              bytes_written_next = bytes_written + 16'd1;
            end
          end
          if (!err) begin
            if (item.in_byte == 8'd0) begin
              err        = 1'b1;
              end_status = cfd_pkg::ST_MALFORMED;
            end else begin
              block_remaining_next = item.in_byte - 8'd1;
              zero_pending_next    = (item.in_byte != cfd_pkg::CODE_FULL);
              first_block_next     = 1'b0;
            end
          end
        end
      end

      if (err) begin
        end_emit            = 1'b1;
        dropping_frame_next = !closing;
      end else if (closing) begin
        // frame close sees the state after this item's byte
        end_emit = 1'b1;
        if (block_remaining_next != 8'd0) begin
          end_status = cfd_pkg::ST_MALFORMED;
        end else begin
          end_len = bytes_written_next;
        end
      end

      if (end_emit) begin
        block_remaining_next = 8'd0;
        zero_pending_next    = 1'b0;
        first_block_next     = 1'b1;
        bytes_written_next   = 16'd0;
      end
    end
  end

  always_comb begin
    push.res0.out_byte     = byte_val;
    push.res0.byte_valid   = 1'b1;
    push.res0.frame_end    = 1'b0;
    push.res0.status       = cfd_pkg::ST_OK;
    push.res0.frame_length = 16'd0;
    push.res1.out_byte     = 8'd0;
    push.res1.byte_valid   = 1'b0;
    push.res1.frame_end    = 1'b1;
    push.res1.status       = end_status;
    push.res1.frame_length = end_len;
    push.push0 = advance && (byte_emit || end_emit);
    push.push1 = advance && byte_emit && end_emit;
    if (!byte_emit) begin
      push.res0 = push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity    <= cfd_pkg::CAPACITY_RESET;
      block_remaining <= 8'd0;
      zero_pending    <= 1'b0;
      first_block     <= 1'b1;
      bytes_written   <= 16'd0;
      dropping_frame  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_capacity <= cfg_wr_data;
      end
      if (advance) begin
        block_remaining <= block_remaining_next;
        zero_pending    <= zero_pending_next;
        first_block     <= first_block_next;
        bytes_written   <= bytes_written_next;
        dropping_frame  <= dropping_frame_next;
      end
    end
  end

endmodule

// ===== rtl/cfd_out_fifo.sv =====
`timescale 1ns / 1ps

module cfd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  cfd_pkg::push_t   push,
  output logic             room_for_two,
  output logic             out_valid,
  input  logic             out_ready,
  output cfd_pkg::result_t head
);

  cfd_pkg::result_t              mem [cfd_pkg::FIFO_DEPTH];
  logic [cfd_pkg::PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [cfd_pkg::CNT_W-1:0]     count;
  logic [cfd_pkg::PTR_W-1:0]     wr_ptr_p1;
  logic                          pop;
  logic [cfd_pkg::CNT_W-1:0]     n_push;

  assign wr_ptr_p1    = wr_ptr + cfd_pkg::PTR_W'(1);
  assign out_valid    = (count != '0);
  assign pop          = out_valid && out_ready;
  assign head         = mem[rd_ptr];
  assign room_for_two = (count <= cfd_pkg::CNT_W'(cfd_pkg::FIFO_DEPTH - 2));
  assign n_push       = cfd_pkg::CNT_W'(push.push0) + cfd_pkg::CNT_W'(push.push1);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cfd_pkg::PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + cfd_pkg::PTR_W'(1);
      end
      count <= count + n_push - cfd_pkg::CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/cobs_frame_decoder.sv =====
`timescale 1ns / 1ps

// Streaming COBS frame decoder.
// Input channel (in_valid/in_ready): one encoded byte per transfer with
// has_byte and last_byte flags; has_byte low closes the frame.
// Output channel (out_valid/out_ready): one result per transfer, either a
// decoded byte (byte_valid) or a frame-end marker (frame_end) with status and,
// on an ok frame, frame_length.
// Configuration: cfg_wr_en writes cfg_wr_data into the capacity register at
// once; write only while the block is idle.
// Path: an item is held in the input register, then decoded into the result
// queue, from which its results are offered; a second result follows the first.
// Throughput: one item per cycle while out_ready stays high and items give
// one result each. An item that gives a byte and a frame end needs two output
// transfers, and the output channel carries one transfer per cycle.
// An item moves from the input register into decode only when the queue has
// room for two results; a stalled receiver fills the queue, then the input
// register, then drops in_ready.
// Reset (rst, synchronous) empties the queue and input register, clears frame
// state and sets the capacity to 65535.

module cobs_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        frame_end,
  output logic [1:0]  status,
  output logic [15:0] frame_length,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  cfd_pkg::item_t   in_reg;
  logic             in_reg_valid;
  logic             advance;
  logic             room_for_two;
  cfd_pkg::push_t   push;
  cfd_pkg::result_t head;

  assign advance  = in_reg_valid && room_for_two;
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg.in_byte   <= in_byte;
      in_reg.has_byte  <= has_byte;
      in_reg.last_byte <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  cfd_step u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_reg),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push)
  );

  cfd_out_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .head         (head)
  );

  assign out_byte     = head.out_byte;
  assign byte_valid   = head.byte_valid;
  assign frame_end    = head.frame_end;
  assign status       = head.status;
  assign frame_length = head.frame_length;

endmodule

// ===== rtl/cfd_checker.sv =====
`timescale 1ns / 1ps

module cfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        frame_end,
  input logic [1:0]  status,
  input logic [15:0] frame_length
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(frame_end) && $stable(status) && $stable(frame_length))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != frame_end))
    else $error("result is neither or both of byte and frame end");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == cfd_pkg::ST_OK && frame_length == 16'd0)
    else $error("byte result carries status or length");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end && status != cfd_pkg::ST_OK |-> frame_length == 16'd0
      && out_byte == 8'd0)
    else $error("error end carries a length");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind cobs_frame_decoder cfd_checker u_cfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .byte_valid   (byte_valid),
  .frame_end    (frame_end),
  .status       (status),
  .frame_length (frame_length)
);

// ===== test/cobs_frame_decoder_tb.sv =====
`timescale 1ns / 1ps

module cobs_frame_decoder_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 35;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        frame_end;
  logic [1:0]  status;
  logic [15:0] frame_length;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  cobs_frame_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .has_byte     (has_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .frame_end    (frame_end),
    .status       (status),
    .frame_length (frame_length),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // decoder shadow state
  logic [15:0]      capacity    = cfd_pkg::CAPACITY_RESET;
  logic [7:0]       blk_left    = 8'd0;
  logic             zero_owed   = 1'b0;
  logic             no_code_yet = 1'b1;
  logic [15:0]      dec_count   = 16'd0;
  logic             skipping    = 1'b0;
  cfd_pkg::result_t pending_results[$];

  int fails        = 0;
  int cycles       = 0;
  int live_items   = 0;
  int results_seen = 0;
  int frames_ended = 0;
  int cap_writes   = 0;
  int hold_left    = 0;
  bit calm         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  task automatic queue_result(input logic [7:0] b, input logic bv, input logic fe,
                              input logic [1:0] st, input logic [15:0] len);
    cfd_pkg::result_t r;
    r.out_byte     = b;
    r.byte_valid   = bv;
    r.frame_end    = fe;
    r.status       = st;
    r.frame_length = len;
    pending_results.push_back(r);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_result(b, 1'b1, 1'b0, cfd_pkg::ST_OK, 16'd0);
    dec_count++;
  endtask

  task automatic restart_frame();
    blk_left    = 8'd0;
    zero_owed   = 1'b0;
    no_code_yet = 1'b1;
    dec_count   = 16'd0;
  endtask

  task automatic abort_frame(input logic [1:0] st, input logic closing);
    queue_result(8'h00, 1'b0, 1'b1, st, 16'd0);
    restart_frame();
    skipping = !closing;
  endtask

  task automatic close_frame();
    if (blk_left != 0) begin
      abort_frame(cfd_pkg::ST_MALFORMED, 1'b1);
    end else begin
      queue_result(8'h00, 1'b0, 1'b1, cfd_pkg::ST_OK, dec_count);
      restart_frame();
    end
  endtask

  task automatic decode_item(input logic [7:0] b, input logic h, input logic l);
    logic closing;
    closing = l || !h;
    if (skipping) begin
      if (closing) skipping = 1'b0;
      return;
    end
    live_items++;
    if (!h) begin
      close_frame();
      return;
    end
    if (blk_left != 0) begin
      if (dec_count >= capacity) begin
        abort_frame(cfd_pkg::ST_TOO_SMALL, closing);
        return;
      end
      queue_byte(b);
      blk_left--;
    end else begin
      // zero owed by the previous block comes out before the new code is used
      if (!no_code_yet && zero_owed) begin
        if (dec_count >= capacity) begin
          abort_frame(cfd_pkg::ST_TOO_SMALL, closing);
          return;
        end
        queue_byte(8'h00);
      end
      if (b == 8'h00) begin
        abort_frame(cfd_pkg::ST_MALFORMED, closing);
        return;
      end
      blk_left    = b - 8'd1;
      zero_owed   = (b != cfd_pkg::CODE_FULL);
      no_code_yet = 1'b0;
    end
    if (l) close_frame();
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cfd_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: out_byte 0x%0h frame_end %0b status %0d",
               out_byte, frame_end, status);
        fails++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.frame_end) frames_ended++;
        check_field("out_byte", want.out_byte, out_byte);
        check_field("byte_valid", want.byte_valid, byte_valid);
        check_field("frame_end", want.frame_end, frame_end);
        check_field("status", want.status, status);
        check_field("frame_length", want.frame_length, frame_length);
      end
    end
  end

  // ---------------------------------------------------------------- input side
  task automatic send_item(input logic [7:0] b, input logic h, input logic l);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT && gap < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    has_byte  <= h;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_item(b, h, l);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_item(seq[i], 1'b1, i == seq.size() - 1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] value);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = value;
    cap_writes++;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 3) return 8'($urandom_range(13, 255));
    return 8'($urandom_range(1, 12));
  endfunction

  // encoded frame with random content; broken frames get a zero code or a cut
  task automatic send_frame(input bit broken);
    logic [7:0] enc[$];
    int         starts[$];
    int         nblk;
    int         code;
    int         cut;
    nblk = $urandom_range(1, 4);
    for (int k = 0; k < nblk; k++) begin
      code = pick_code();
      starts.push_back(enc.size());
      enc.push_back(8'(code));
      for (int j = 1; j < code; j++) enc.push_back(8'($urandom_range(255)));
    end
    if (broken) begin
      if ($urandom_range(1) == 0) begin
        enc[starts[$urandom_range(starts.size() - 1)]] = 8'h00;
      end else begin
        cut = $urandom_range(1, enc.size());
        while (enc.size() > cut) void'(enc.pop_back());
      end
    end
    if ($urandom_range(99) < 85) begin
      send_bytes(enc);
    end else begin
      foreach (enc[i]) send_item(enc[i], 1'b1, 1'b0);
      send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_item(8'hA5, 1'b0, 1'b0);                 // empty frame
    send_item(8'h00, 1'b0, 1'b1);                 // close item with last set
    send_bytes('{8'h03, 8'h11, 8'h22, 8'h02, 8'h33});
    send_bytes('{8'h01});                         // trailing zero never shows
    send_bytes('{8'h01, 8'h01});
    send_bytes('{8'h02, 8'hFF, 8'h00, 8'h05, 8'h06}); // zero code, rest dropped
    send_bytes('{8'h04, 8'h00, 8'h80});           // block cut short by last
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'h10, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);                 // block cut short by close
    send_bytes('{8'h00});                         // zero code that also closes
    wait_drain();
  endtask

  task automatic test_capacity();
    set_capacity(16'd0);
    send_bytes('{8'h01});
    send_bytes('{8'h02, 8'h55});                  // overflow on the closing item
    send_bytes('{8'h01, 8'h01, 8'h07});           // owed zero overflows, drop
    set_capacity(16'd3);
    send_bytes('{8'h04, 8'h01, 8'h02, 8'h03});
    send_bytes('{8'h03, 8'h01, 8'h02, 8'h02, 8'h09});
    set_capacity(cfd_pkg::CAPACITY_RESET);
  endtask

  task automatic test_full_block();
    logic [7:0] enc[$];
    enc.push_back(cfd_pkg::CODE_FULL);
    for (int j = 0; j < 254; j++) enc.push_back(8'($urandom_range(255)));
    foreach (enc[i]) send_item(enc[i], 1'b1, 1'b0);
    send_bytes('{8'h02, 8'h77});                  // no zero after a full block
    wait_drain();
  endtask

  task automatic test_streaming();
    int start;
    calm  = 1'b1;
    start = live_items;
    while (live_items - start < 40) send_frame(1'b0);
    wait_drain();
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    int start;
    // receiver holds off while the sender keeps going, so in_ready must drop
    hold_left = 150;
    calm      = 1'b1;
    start     = live_items;
    while (live_items - start < 30) send_frame(1'b0);
    calm = 1'b0;
    wait_drain();
    repeat (2) send_frame($urandom_range(1));
    wait_drain();
  endtask

  task automatic test_random();
    logic [15:0] caps[5];
    int          start;
    int          pick;
    caps[0] = cfd_pkg::CAPACITY_RESET;
    caps[1] = 16'd0;
    caps[2] = 16'($urandom_range(1, 8));
    caps[3] = 16'($urandom_range(65535));
    caps[4] = 16'($urandom_range(2, 30));
    for (int p = 0; p < 5; p++) begin
      set_capacity(caps[p]);
      start = live_items;
      while (live_items - start < 12) begin
        pick = $urandom_range(99);
        if (pick < 70)
          send_frame(1'b0);
        else if (pick < 85)
          send_frame(1'b1);
        else
          send_item(8'($urandom_range(255)), 1'($urandom_range(99) < 90),
                    1'($urandom_range(99) < 20));
      end
    end
    set_capacity(cfd_pkg::CAPACITY_RESET);
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_full_block();
    test_streaming();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fails++;
    end

    $display("Decoded %0d live items into %0d results, %0d of them frame ends.",
             live_items, results_seen, frames_ended);
    $display("Capacity written %0d times, from 0 to 65535; %0d mismatches.",
             cap_writes, fails);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
